FILE: hw/rtl/curve_vertex_cull_compactor_macros.svh
// assertion macros for the curve vertex cull compactor checker
// no dependencies; taken in by the checker file
`ifndef CURVE_VERTEX_CULL_COMPACTOR_MACROS_SVH
`define CURVE_VERTEX_CULL_COMPACTOR_MACROS_SVH

// checked only outside reset
`define CVCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CVCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/cvcc_pkg.sv
// shared types, codes and record builders for the curve vertex cull compactor
// no dependencies
package cvcc_pkg;

  localparam int FIELD_W        = 24;
  localparam int INDEX_BITS_DEF = 24;
  localparam int MAX_RES        = 3;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);
  localparam int APB_ADDR_W     = 2;
  localparam int APB_DATA_W     = 32;

  // request codes
  localparam logic [1:0] REQ_POINT = 2'd0;
  localparam logic [1:0] REQ_EMPTY = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  // record kinds
  localparam logic [1:0] KIND_POINT   = 2'd0;
  localparam logic [1:0] KIND_CURVE   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] BASIS_BEZIER = 2'd1;

  // register addresses
  localparam logic [APB_ADDR_W-1:0] ADDR_BASIS = 2'd0;

  typedef struct packed {
    logic [1:0]         record_kind;
    logic [FIELD_W-1:0] orig_index;
    logic [FIELD_W-1:0] vertex_count;
    logic               force_linear;
    logic               all_removed;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic [1:0]                 cnt;
    result_t [MAX_RES-1:0]      rec;
  } push_t;

  function automatic result_t mk_point(logic [FIELD_W-1:0] idx);
    result_t r;
    r              = '0;
    r.record_kind  = KIND_POINT;
    r.orig_index   = idx;
    return r;
  endfunction

  function automatic result_t mk_curve(logic [FIELD_W-1:0] idx, logic [FIELD_W-1:0] cnt);
    result_t r;
    r              = '0;
    r.record_kind  = KIND_CURVE;
    r.orig_index   = idx;
    r.vertex_count = cnt;
    return r;
  endfunction

  function automatic result_t mk_summary(logic [FIELD_W-1:0] cnt, logic lin, logic none);
    result_t r;
    r              = '0;
    r.record_kind  = KIND_SUMMARY;
    r.vertex_count = cnt;
    r.force_linear = lin;
    r.all_removed  = none;
    return r;
  endfunction

endpackage

FILE: hw/rtl/cvcc_cfg.sv
// apb register block: holds the curve basis code
// depends on cvcc_pkg
module cvcc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cvcc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [cvcc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [cvcc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [1:0]                       basis_code
);
  import cvcc_pkg::*;

  logic wr_basis;

  assign pready   = 1'b1;
  assign wr_basis = psel & penable & pwrite & (paddr == ADDR_BASIS);

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_code <= 2'd0;
    end else if (wr_basis) begin
      basis_code <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_BASIS) begin
      prdata[1:0] = basis_code;
    end
  end

endmodule

FILE: hw/rtl/cvcc_core.sv
// input register, curve bookkeeping state and per-item record generation
// depends on cvcc_pkg
module cvcc_core #(
  parameter int INDEX_BITS = cvcc_pkg::INDEX_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      req_type,
  input  logic            point_omitted,
  input  logic            ends_curve,
  input  logic [1:0]      basis_code,
  input  logic            room,
  output cvcc_pkg::push_t push
);
  import cvcc_pkg::*;

  localparam logic [INDEX_BITS-1:0] CNT_MAX = '1;
  localparam logic [INDEX_BITS-1:0] ONE     = INDEX_BITS'(1);
  localparam logic [INDEX_BITS-1:0] FOUR    = INDEX_BITS'(4);

  // input register
  logic       in_full;
  logic [1:0] r_type;
  logic       r_omit;
  logic       r_ends;
  logic       accept;
  logic       fire;

  // bookkeeping state
  logic [INDEX_BITS-1:0] point_counter, point_counter_next;
  logic [INDEX_BITS-1:0] curve_counter, curve_counter_next;
  logic [INDEX_BITS-1:0] kept_in_curve, kept_in_curve_next;
  logic [1:0]            kept_mod_three, kept_mod_three_next;
  logic [INDEX_BITS-1:0] held_point_index, held_point_index_next;
  logic                  linear_needed, linear_needed_next;
  logic [INDEX_BITS-1:0] curves_kept, curves_kept_next;

  logic [INDEX_BITS-1:0] pc_inc, cc_inc, kic_inc, ck_inc;
  logic [INDEX_BITS-1:0] kic_upd;
  logic [1:0]            m3_upd;

  assign fire     = in_full & room;
  assign in_stall = in_full & ~room;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= accept | (in_full & ~fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_type <= req_type;
      r_omit <= point_omitted;
      r_ends <= ends_curve;
    end
  end

  // saturating increments
  assign pc_inc  = (point_counter == CNT_MAX) ? point_counter : point_counter + ONE;
  assign cc_inc  = (curve_counter == CNT_MAX) ? curve_counter : curve_counter + ONE;
  assign kic_inc = (kept_in_curve == CNT_MAX) ? kept_in_curve : kept_in_curve + ONE;
  assign ck_inc  = (curves_kept == CNT_MAX) ? curves_kept : curves_kept + ONE;

  always_comb begin
    point_counter_next    = point_counter;
    curve_counter_next    = curve_counter;
    kept_in_curve_next    = kept_in_curve;
    kept_mod_three_next   = kept_mod_three;
    held_point_index_next = held_point_index;
    linear_needed_next    = linear_needed;
    curves_kept_next      = curves_kept;
    kic_upd               = kept_in_curve;
    m3_upd                = kept_mod_three;
    push                  = '0;
    if (fire) begin
      case (r_type)
        REQ_POINT: begin
          point_counter_next = pc_inc;
          if (!r_omit) begin
            if (kept_in_curve == '0) begin
              // first kept point waits until a second one shows the curve survives
              held_point_index_next = point_counter;
            end else if (kept_in_curve == ONE) begin
              push.rec[0] = mk_point(FIELD_W'(held_point_index));
              push.rec[1] = mk_point(FIELD_W'(point_counter));
              push.cnt    = 2'd2;
            end else begin
              push.rec[0] = mk_point(FIELD_W'(point_counter));
              push.cnt    = 2'd1;
            end
            kic_upd = kic_inc;
            m3_upd  = (kept_mod_three == 2'd2) ? 2'd0 : kept_mod_three + 2'd1;
          end
          kept_in_curve_next  = kic_upd;
          kept_mod_three_next = m3_upd;
          if (r_ends) begin
            if (kic_upd > ONE) begin
              if (kic_upd < FOUR || (basis_code == BASIS_BEZIER && m3_upd != 2'd1)) begin
                linear_needed_next = 1'b1;
              end
              push.rec[push.cnt] = mk_curve(FIELD_W'(curve_counter), FIELD_W'(kic_upd));
              push.cnt           = push.cnt + 2'd1;
              curves_kept_next   = ck_inc;
            end
            curve_counter_next  = cc_inc;
            kept_in_curve_next  = '0;
            kept_mod_three_next = 2'd0;
          end
        end
        REQ_EMPTY: begin
          curve_counter_next = cc_inc;
        end
        REQ_END: begin
          push.rec[0] = mk_summary(FIELD_W'(curves_kept), linear_needed,
                                   curves_kept == '0);
          push.cnt            = 2'd1;
          point_counter_next  = '0;
          curve_counter_next  = '0;
          kept_in_curve_next  = '0;
          kept_mod_three_next = 2'd0;
          linear_needed_next  = 1'b0;
          curves_kept_next    = '0;
        end
        default: begin
        end
      endcase
      if (push.cnt != 2'd0) begin
        push.rec[push.cnt - 2'd1].last_result = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_counter  <= '0;
      curve_counter  <= '0;
      kept_in_curve  <= '0;
      kept_mod_three <= 2'd0;
      linear_needed  <= 1'b0;
      curves_kept    <= '0;
    end else begin
      point_counter  <= point_counter_next;
      curve_counter  <= curve_counter_next;
      kept_in_curve  <= kept_in_curve_next;
      kept_mod_three <= kept_mod_three_next;
      linear_needed  <= linear_needed_next;
      curves_kept    <= curves_kept_next;
    end
  end

  always_ff @(posedge clk) begin
    held_point_index <= held_point_index_next;
  end

endmodule

FILE: hw/rtl/cvcc_resq.sv
// result queue: takes up to three records a cycle, hands out one a cycle while out_stall is low
// depends on cvcc_pkg
module cvcc_resq (
  input  logic              clk,
  input  logic              rst,
  input  cvcc_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output cvcc_pkg::result_t out_rec
);
  import cvcc_pkg::*;

  result_t             q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                pop;

  assign out_valid = (count != '0);
  assign out_rec   = q[rd_ptr];
  assign pop       = out_valid & ~out_stall;
  // room for a full burst of records from one item
  assign room      = (count <= QCNT_W'(QDEPTH - MAX_RES));

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push.cnt) begin
        q[wr_ptr + QPTR_W'(i)] <= push.rec[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.cnt);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push.cnt) - QCNT_W'(pop);
    end
  end

endmodule

FILE: hw/rtl/curve_vertex_cull_compactor.sv
// curve vertex cull compactor: control points in, kept point, curve and summary records out
// top level; depends on cvcc_pkg, cvcc_cfg, cvcc_core, cvcc_resq
//
// input channel: in_valid / in_stall with req_type, point_omitted, ends_curve.
// one item is a control point, an empty curve or the end of a set.
// output channel: out_valid / out_stall with one record per transfer;
// last_result marks the final record an item produced (one item gives 0 to 3).
// apb port: register 0 is basis_code (1 = bezier); write only while idle.
// an accepted item is held in the input register until the result queue has
// room; its records then enter the queue and leave it in order.
// throughput: one item per cycle while out_stall is low and no item gives more
// than one record; the output side drains the 4-entry result queue one record
// per cycle while out_stall is low.
// the input register advances only with 3 free queue entries, so in_stall
// rises when out_stall backs the queue up; nothing is dropped.
// reset clears counters, flags, the queue and basis_code; no clearing pass.
module curve_vertex_cull_compactor #(
  parameter int INDEX_BITS = cvcc_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       req_type,
  input  logic                             point_omitted,
  input  logic                             ends_curve,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       record_kind,
  output logic [cvcc_pkg::FIELD_W-1:0]     orig_index,
  output logic [cvcc_pkg::FIELD_W-1:0]     vertex_count,
  output logic                             force_linear,
  output logic                             all_removed,
  output logic                             last_result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cvcc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [cvcc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [cvcc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import cvcc_pkg::*;

  logic [1:0] basis_code;
  logic       room;
  push_t      push;
  result_t    out_rec;

  cvcc_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .basis_code (basis_code)
  );

  cvcc_core #(
    .INDEX_BITS (INDEX_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .point_omitted (point_omitted),
    .ends_curve    (ends_curve),
    .basis_code    (basis_code),
    .room          (room),
    .push          (push)
  );

  cvcc_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rec   (out_rec)
  );

  assign record_kind  = out_rec.record_kind;
  assign orig_index   = out_rec.orig_index;
  assign vertex_count = out_rec.vertex_count;
  assign force_linear = out_rec.force_linear;
  assign all_removed  = out_rec.all_removed;
  assign last_result  = out_rec.last_result;

endmodule

FILE: hw/rtl/cvcc_checker.sv
// port-level checks for the curve vertex cull compactor, bound to the top level
// depends on cvcc_pkg and curve_vertex_cull_compactor_macros.svh
`include "curve_vertex_cull_compactor_macros.svh"

module cvcc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   record_kind,
  input logic [cvcc_pkg::FIELD_W-1:0] orig_index,
  input logic [cvcc_pkg::FIELD_W-1:0] vertex_count,
  input logic                         force_linear,
  input logic                         all_removed,
  input logic                         last_result
);
  import cvcc_pkg::*;

  `CVCC_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !out_valid, "item shown right after reset")

  `CVCC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(record_kind) && $stable(orig_index) && $stable(vertex_count) && $stable(last_result), "stalled item changed")

  `CVCC_ASSERT(a_summary_last, out_valid && record_kind == KIND_SUMMARY |-> last_result && orig_index == '0 && all_removed == (vertex_count == '0), "summary item malformed")

  `CVCC_ASSERT(a_flags_summary_only, out_valid && (record_kind == KIND_POINT || record_kind == KIND_CURVE) |-> !force_linear && !all_removed, "summary flags on a non-summary item")

  `CVCC_ASSERT(a_curve_count, out_valid && record_kind == KIND_CURVE |-> last_result && vertex_count > FIELD_W'(1), "curve item with fewer than two points")

endmodule

bind curve_vertex_cull_compactor cvcc_checker u_cvcc_checker (.*);

FILE: sim/curve_vertex_cull_compactor_test.sv
// self-checking bench for curve_vertex_cull_compactor: random and directed control point streams
// are checked record by record against a built-in model of the culling; depends on cvcc_pkg
// and the rtl under hw/rtl
module curve_vertex_cull_compactor_test;
  import cvcc_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         QUIET_LIMIT = 3000;

  typedef struct {
    logic [1:0] req;
    logic       omit;
    logic       ends;
  } cp_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            req_type = REQ_POINT;
  logic                  point_omitted = 1'b0;
  logic                  ends_curve = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            record_kind;
  logic [FIELD_W-1:0]    orig_index;
  logic [FIELD_W-1:0]    vertex_count;
  logic                  force_linear;
  logic                  all_removed;
  logic                  last_result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = ADDR_BASIS;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  curve_vertex_cull_compactor uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .point_omitted(point_omitted), .ends_curve(ends_curve),
    .out_valid(out_valid), .out_stall(out_stall),
    .record_kind(record_kind), .orig_index(orig_index), .vertex_count(vertex_count),
    .force_linear(force_linear), .all_removed(all_removed), .last_result(last_result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // model state of the culling
  logic [FIELD_W-1:0] next_point = '0;
  logic [FIELD_W-1:0] next_curve = '0;
  logic [FIELD_W-1:0] kept_run = '0;
  logic [1:0]         kept_mod3 = '0;
  logic [FIELD_W-1:0] held_idx = '0;
  logic               want_linear = 1'b0;
  logic [FIELD_W-1:0] curves_out = '0;
  logic [1:0]         basis_sel = '0;

  cp_item_t pending_items[$];
  result_t  want_records[$];

  int items_queued = 0;
  int items_accepted = 0;
  int errors = 0;
  int point_recs = 0;
  int curve_recs = 0;
  int summary_recs = 0;
  bit steady = 1'b0;

  int gap_left = 0;
  int in_calm = 0;
  int stall_left = 0;
  int out_calm = 0;
  int quiet_cycles = 0;

  function automatic logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic result_t make_rec(logic [1:0] kind, logic [FIELD_W-1:0] idx,
                                       logic [FIELD_W-1:0] cnt, logic fl, logic ar);
    result_t r;
    r.record_kind  = kind;
    r.orig_index   = idx;
    r.vertex_count = cnt;
    r.force_linear = fl;
    r.all_removed  = ar;
    r.last_result  = 1'b0;
    return r;
  endfunction

  // works out the records one item causes and queues them
  function automatic void cull_predict(cp_item_t it);
    result_t            recs[$];
    logic [FIELD_W-1:0] idx;
    if (it.req == REQ_POINT) begin
      idx = next_point;
      next_point = bump(next_point);
      if (!it.omit) begin
        if (kept_run == 0) begin
          held_idx = idx;
        end else if (kept_run == 1) begin
          // second kept point releases the held one
          recs = {recs, make_rec(KIND_POINT, held_idx, '0, 1'b0, 1'b0)};
          recs = {recs, make_rec(KIND_POINT, idx, '0, 1'b0, 1'b0)};
        end else begin
          recs = {recs, make_rec(KIND_POINT, idx, '0, 1'b0, 1'b0)};
        end
        kept_run = bump(kept_run);
        kept_mod3 = (kept_mod3 >= 2) ? 2'd0 : kept_mod3 + 2'd1;
      end
      if (it.ends) begin
        if (kept_run > 1) begin
          if (kept_run < 4 || (basis_sel == BASIS_BEZIER && kept_mod3 != 1))
            want_linear = 1'b1;
          recs = {recs, make_rec(KIND_CURVE, next_curve, kept_run, 1'b0, 1'b0)};
          curves_out = bump(curves_out);
        end
        next_curve = bump(next_curve);
        kept_run = '0;
        kept_mod3 = '0;
      end
    end else if (it.req == REQ_EMPTY) begin
      next_curve = bump(next_curve);
    end else if (it.req == REQ_END) begin
      recs = {recs, make_rec(KIND_SUMMARY, '0, curves_out, want_linear, curves_out == 0)};
      next_point = '0;
      next_curve = '0;
      kept_run = '0;
      kept_mod3 = '0;
      held_idx = '0;
      want_linear = 1'b0;
      curves_out = '0;
    end
    if (recs.size() > 0)
      recs[recs.size()-1].last_result = 1'b1;
    foreach (recs[i])
      want_records = {want_records, recs[i]};
  endfunction

  function automatic void check_field(string name, logic [FIELD_W-1:0] exp,
                                      logic [FIELD_W-1:0] got);
    if (got !== exp) begin
      $error("%s: expected %0d, got %0d", name, exp, got);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk) begin : drive_items
    cp_item_t cur;
    cp_item_t nxt;
    logic     take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        cur.req  = req_type;
        cur.omit = point_omitted;
        cur.ends = ends_curve;
        cull_predict(cur);
        items_accepted++;
      end
      if (in_calm > 0)
        in_calm--;
      if (!in_valid || take) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          in_valid      <= 1'b1;
          req_type      <= nxt.req;
          point_omitted <= nxt.omit;
          ends_curve    <= nxt.ends;
          if (!steady && in_calm == 0 && $urandom_range(7) == 0) begin
            gap_left = $urandom_range(1, 18);
            if ($urandom_range(3) == 0)
              in_calm = gap_left + $urandom_range(30, 100);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and output stall
  always @(posedge clk) begin : watch_records
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_records.size() == 0) begin
          $error("unexpected record: kind %0d index %0d count %0d",
                 record_kind, orig_index, vertex_count);
          errors++;
        end else begin
          want = want_records.pop_front();
          check_field("record_kind", FIELD_W'(want.record_kind), FIELD_W'(record_kind));
          check_field("orig_index", want.orig_index, orig_index);
          check_field("vertex_count", want.vertex_count, vertex_count);
          check_field("force_linear", FIELD_W'(want.force_linear), FIELD_W'(force_linear));
          check_field("all_removed", FIELD_W'(want.all_removed), FIELD_W'(all_removed));
          check_field("last_result", FIELD_W'(want.last_result), FIELD_W'(last_result));
        end
        case (record_kind)
          KIND_POINT: point_recs++;
          KIND_CURVE: curve_recs++;
          default:    summary_recs++;
        endcase
      end
      if (out_calm > 0)
        out_calm--;
      if (stall_left > 0) begin
        stall_left--;
      end else if (!steady && out_calm == 0 && $urandom_range(9) == 0) begin
        stall_left = $urandom_range(1, 18);
        if ($urandom_range(3) == 0)
          out_calm = stall_left + $urandom_range(30, 100);
      end
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: %0d items still pending, %0d records outstanding",
               items_queued - items_accepted, want_records.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_item(logic [1:0] req, logic omit, logic ends);
    cp_item_t it;
    it.req  = req;
    it.omit = omit;
    it.ends = ends;
    pending_items = {pending_items, it};
    items_queued++;
  endtask

  task automatic add_curve(int len, int omit_pct);
    for (int i = 0; i < len; i++) begin
      // rare stray item inside a curve
      if (i > 0 && $urandom_range(29) == 0)
        add_item(($urandom_range(1) == 0) ? REQ_EMPTY : REQ_UNUSED,
                 1'($urandom_range(1)), 1'($urandom_range(1)));
      add_item(REQ_POINT, $urandom_range(99) < omit_pct, i == len - 1);
    end
  endtask

  task automatic gen_set();
    int n_curves;
    int len;
    int pct;
    bit clean;
    n_curves = $urandom_range(1, 6);
    clean = ($urandom_range(3) == 0);
    for (int c = 0; c < n_curves; c++) begin
      if (clean) begin
        add_curve(3 * $urandom_range(1, 3) + 1, 0);
      end else begin
        case ($urandom_range(9))
          0: add_item(REQ_EMPTY, 1'($urandom_range(1)), 1'($urandom_range(1)));
          1: add_item(REQ_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)));
          default: begin
            len = ($urandom_range(7) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
            case ($urandom_range(4))
              0, 1:    pct = 0;
              2:       pct = 30;
              3:       pct = 60;
              default: pct = 100;
            endcase
            add_curve(len, pct);
          end
        endcase
      end
    end
    // sometimes the set ends inside an unfinished curve
    if ($urandom_range(7) == 0)
      for (int i = $urandom_range(1, 3); i > 0; i--)
        add_item(REQ_POINT, 1'($urandom_range(1)), 1'b0);
    add_item(REQ_END, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic random_phase(int target);
    int start;
    start = items_queued;
    while (items_queued - start < target)
      gen_set();
  endtask

  task automatic drain();
    while (items_accepted != items_queued || want_records.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    logic [APB_DATA_W-1:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    basis_sel = data[1:0];
    // straight into a read back of the same register
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[1:0] !== data[1:0]) begin
      $error("basis_code: expected %0d, got %0d", data[1:0], got[1:0]);
      errors++;
    end
  endtask

  initial begin : run
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty set, ignored fields, lone and dropped points, short curves
    add_item(REQ_END, 1'b0, 1'b0);
    add_item(REQ_EMPTY, 1'b1, 1'b1);
    add_item(REQ_POINT, 1'b0, 1'b1);
    add_item(REQ_POINT, 1'b1, 1'b1);
    add_item(REQ_POINT, 1'b0, 1'b0);
    add_item(REQ_POINT, 1'b0, 1'b1);
    add_item(REQ_POINT, 1'b0, 1'b0);
    add_item(REQ_POINT, 1'b1, 1'b0);
    add_item(REQ_POINT, 1'b0, 1'b0);
    add_item(REQ_POINT, 1'b0, 1'b1);
    for (int i = 0; i < 5; i++)
      add_item(REQ_POINT, 1'b0, i == 4);
    add_item(REQ_UNUSED, 1'b1, 1'b1);
    add_item(REQ_POINT, 1'b0, 1'b0);
    add_item(REQ_POINT, 1'b0, 1'b0);
    add_item(REQ_END, 1'b1, 1'b1);
    add_item(REQ_EMPTY, 1'b0, 1'b0);
    add_item(REQ_POINT, 1'b1, 1'b0);
    add_item(REQ_POINT, 1'b0, 1'b1);
    add_item(REQ_END, 1'b0, 1'b1);

    random_phase(90);
    drain();
    random_phase(50);
    drain();

    reg_write(ADDR_BASIS, 32'(BASIS_BEZIER));
    random_phase(110);
    drain();

    reg_write(ADDR_BASIS, 32'd3);
    random_phase(80);
    drain();

    reg_write(ADDR_BASIS, 32'd2);
    random_phase(40);
    drain();

    reg_write(ADDR_BASIS, 32'd0);
    steady = 1'b1;
    random_phase(40);
    drain();

    $display("checked %0d items over basis codes 0 to 3 with random stalls on both sides",
             items_accepted);
    $display("records seen: %0d points, %0d curves, %0d set summaries",
             point_recs, curve_recs, summary_recs);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
